/* hdl/i2a_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and the digit-to-ASCII function of the integer formatter.
package i2a_pkg;

  localparam int unsigned MAG_W      = 64;
  localparam int unsigned VALUE_BITS = 64;
  localparam int unsigned MAX_FIELD  = 64;
  localparam int unsigned RUN_MAX    = 64;

  // octal always needs the most digit slots of the three radixes
  localparam int unsigned OCT_DIGITS = (VALUE_BITS + 2) / 3;
  localparam int unsigned DIG_SLOTS  = OCT_DIGITS;
  localparam int unsigned SLOT_BITS  = 4 * DIG_SLOTS;
  localparam int unsigned CNT_W      = $clog2(DIG_SLOTS + 1);
  localparam int unsigned BITCNT_W   = $clog2(VALUE_BITS + 1);
  localparam int unsigned LEN_W      = $clog2(RUN_MAX + 1);
  localparam int unsigned SUM_W      = LEN_W + 1;

  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_A_UP  = 8'h41;

  typedef struct packed {
    logic              negative;
    logic [1:0]        opcode;
    logic              upper_case;
    logic [6:0]        field_width;
    logic signed [6:0] min_digits;
    logic              zero_fill;
    logic              align_left;
    logic              force_plus;
    logic              alternate;
    logic              is_zero;
  } fmt_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] ndig;
    logic [3:0]       top_digit;
  } dig_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic up);
    logic [7:0] base;
    base = up ? CH_A_UP : CH_A_LO;
    if (d < 4'd10) begin
      return CH_ZERO + 8'(d);
    end
    return base + 8'(d) - 8'd10;
  endfunction

endpackage

/* hdl/i2a_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the number word in and the character word out.
interface i2a_in_if;
  logic                           valid;
  logic                           ready;
  logic [i2a_pkg::MAG_W-1:0]      magnitude;
  logic                           negative;
  logic [1:0]                     opcode;
  logic                           upper_case;
  logic [6:0]                     field_width;
  logic signed [6:0]              min_digits;
  logic                           zero_fill;
  logic                           align_left;
  logic                           force_plus;
  logic                           alternate;

  modport source (
    output valid, magnitude, negative, opcode, upper_case, field_width, min_digits,
           zero_fill, align_left, force_plus, alternate,
    input  ready
  );
  modport sink (
    input  valid, magnitude, negative, opcode, upper_case, field_width, min_digits,
           zero_fill, align_left, force_plus, alternate,
    output ready
  );
endinterface

interface i2a_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;

  modport source (output valid, out_char, last_char, input ready);
  modport sink (input valid, out_char, last_char, output ready);
endinterface

/* hdl/i2a_digits.sv */
`timescale 1ns / 1ps
// Digit register: bit-serial binary-to-BCD, octal/hex load, leading-zero strip, digit shift-out.
module i2a_digits (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [i2a_pkg::VALUE_BITS-1:0]   magnitude_i,
  input  logic [1:0]                       opcode_i,
  input  logic                             shift_i,
  output i2a_pkg::dig_stat_t               stat_o
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_DABBLE = 2'd1;
  localparam logic [1:0] PH_NORM   = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;
  localparam int unsigned OCT_BITS = 3 * i2a_pkg::OCT_DIGITS;

  logic [1:0]                          phase_q, phase_d;
  logic [i2a_pkg::SLOT_BITS-1:0]       slots_q, slots_d;
  logic [i2a_pkg::SLOT_BITS-1:0]       adj, oct_load;
  logic [i2a_pkg::VALUE_BITS-1:0]      bits_q, bits_d;
  logic [i2a_pkg::BITCNT_W-1:0]        bitcnt_q, bitcnt_d;
  logic [i2a_pkg::CNT_W-1:0]           cnt_q, cnt_d;
  logic [OCT_BITS-1:0]                 mag_oct;
  logic [3:0]                          top_nib;

  assign mag_oct = OCT_BITS'(magnitude_i);
  assign top_nib = slots_q[i2a_pkg::SLOT_BITS-1 -: 4];

  always_comb begin
    for (int i = 0; i < i2a_pkg::DIG_SLOTS; i++) begin
      oct_load[4*i +: 4] = {1'b0, mag_oct[3*i +: 3]};
      adj[4*i +: 4] = (slots_q[4*i +: 4] >= 4'd5) ? slots_q[4*i +: 4] + 4'd3
                                                  : slots_q[4*i +: 4];
    end
  end

  always_comb begin
    phase_d  = phase_q;
    slots_d  = slots_q;
    bits_d   = bits_q;
    bitcnt_d = bitcnt_q;
    cnt_d    = cnt_q;
    if (start_i) begin
      cnt_d    = i2a_pkg::CNT_W'(i2a_pkg::DIG_SLOTS);
      bits_d   = magnitude_i;
      bitcnt_d = i2a_pkg::BITCNT_W'(i2a_pkg::VALUE_BITS);
      unique case (opcode_i)
        i2a_pkg::RADIX_OCT: begin
          slots_d = oct_load;
          phase_d = PH_NORM;
        end
        i2a_pkg::RADIX_HEX: begin
          slots_d = i2a_pkg::SLOT_BITS'(magnitude_i);
          phase_d = PH_NORM;
        end
        i2a_pkg::RADIX_DEC: begin
          slots_d = '0;
          phase_d = PH_DABBLE;
        end
        default: begin
          // reserved radix code runs as decimal
          slots_d = '0;
          phase_d = PH_DABBLE;
        end
      endcase
    end else begin
      unique case (phase_q)
        PH_DABBLE: begin
          // add-3 on every BCD digit of 5 or more, then shift the next binary bit in
          slots_d  = {adj[i2a_pkg::SLOT_BITS-2:0], bits_q[i2a_pkg::VALUE_BITS-1]};
          bits_d   = bits_q << 1;
          bitcnt_d = bitcnt_q - 1'b1;
          if (bitcnt_q == i2a_pkg::BITCNT_W'(1)) begin
            phase_d = PH_NORM;
          end
        end
        PH_NORM: begin
          if (cnt_q != '0 && top_nib == 4'd0) begin
            slots_d = slots_q << 4;
            cnt_d   = cnt_q - 1'b1;
          end else begin
            phase_d = PH_DONE;
          end
        end
        PH_DONE: begin
          if (shift_i) begin
            slots_d = slots_q << 4;
          end
        end
        PH_IDLE: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slots_q  <= slots_d;
    bits_q   <= bits_d;
    bitcnt_q <= bitcnt_d;
    cnt_q    <= cnt_d;
  end

  assign stat_o.done      = (phase_q == PH_DONE);
  assign stat_o.ndig      = cnt_q;
  assign stat_o.top_digit = top_nib;

endmodule

/* hdl/i2a_emit.sv */
`timescale 1ns / 1ps
// Field layout and character sequencer with the output word register.
module i2a_emit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  i2a_pkg::fmt_t        fmt_i,
  input  i2a_pkg::dig_stat_t   dig_i,
  output logic                 shift_o,
  output logic                 busy_o,
  i2a_out_if.source            out_o
);

  localparam logic [2:0] EP_IDLE  = 3'd0;
  localparam logic [2:0] EP_CALC1 = 3'd1;
  localparam logic [2:0] EP_CALC2 = 3'd2;
  localparam logic [2:0] EP_CALC3 = 3'd3;
  localparam logic [2:0] EP_RUN   = 3'd4;
  localparam int unsigned LW = i2a_pkg::LEN_W;
  localparam int unsigned SW = i2a_pkg::SUM_W;

  logic [2:0]                 phase_q, phase_d;
  logic [i2a_pkg::CNT_W-1:0]  ndig_q, ndig_d;
  logic [LW-1:0]              pz_q, pz_d;
  logic [1:0]                 plen_q, plen_d;
  logic [7:0]                 pre_q [3];
  logic [7:0]                 pre_d [3];
  logic                       zf_q, zf_d;
  logic [LW-1:0]              content_q, content_d;
  logic [LW-1:0]              b1_q, b1_d, b2_q, b2_d, b4_q, b4_d, b5_q, b5_d;
  logic [LW-1:0]              total_q, total_d;
  logic [LW-1:0]              idx_q, idx_d;
  logic                       valid_q, valid_d;
  logic [7:0]                 char_q, char_d;
  logic                       last_q, last_d;

  logic                       has_prec;
  logic [LW-1:0]              prec_l, ndig_l, pz_c;
  logic                       sign_on, hex_alt, oct_alt;
  logic [7:0]                 sign_ch, x_ch;
  logic [SW-1:0]              content_c;
  logic [LW-1:0]              fw_c, pad_c, lead_c, zpad_c, trail_c;
  logic [LW-1:0]              pre_off;
  logic                       load;

  assign has_prec = !fmt_i.min_digits[6];
  assign prec_l   = LW'(fmt_i.min_digits[5:0]);
  assign ndig_l   = LW'(ndig_q);
  assign pz_c     = (has_prec && prec_l > ndig_l) ? prec_l - ndig_l : '0;
  assign sign_on  = fmt_i.negative || fmt_i.force_plus;
  assign sign_ch  = fmt_i.negative ? i2a_pkg::CH_MINUS : i2a_pkg::CH_PLUS;
  assign x_ch     = fmt_i.upper_case ? i2a_pkg::CH_X_UP : i2a_pkg::CH_X_LO;
  assign hex_alt  = fmt_i.alternate && fmt_i.opcode == i2a_pkg::RADIX_HEX;
  // octal '0' only when the digits would not already open with a zero
  assign oct_alt  = fmt_i.alternate && fmt_i.opcode == i2a_pkg::RADIX_OCT && pz_c == '0
                    && !(fmt_i.is_zero && ndig_q != '0);

  assign content_c = SW'(plen_q) + SW'(pz_q) + SW'(ndig_q);

  assign fw_c    = (fmt_i.field_width > 7'(i2a_pkg::MAX_FIELD)) ? LW'(i2a_pkg::MAX_FIELD)
                                                               : LW'(fmt_i.field_width);
  assign pad_c   = (fw_c > content_q) ? fw_c - content_q : '0;
  assign lead_c  = (!fmt_i.align_left && !zf_q) ? pad_c : '0;
  assign zpad_c  = (!fmt_i.align_left && zf_q) ? pad_c : '0;
  assign trail_c = fmt_i.align_left ? pad_c : '0;

  assign load    = !valid_q || out_o.ready;
  assign pre_off = idx_q - b1_q;

  always_comb begin
    phase_d   = phase_q;
    ndig_d    = ndig_q;
    pz_d      = pz_q;
    plen_d    = plen_q;
    pre_d     = pre_q;
    zf_d      = zf_q;
    content_d = content_q;
    b1_d      = b1_q;
    b2_d      = b2_q;
    b4_d      = b4_q;
    b5_d      = b5_q;
    total_d   = total_q;
    idx_d     = idx_q;
    valid_d   = valid_q && !out_o.ready;
    char_d    = char_q;
    last_d    = last_q;
    shift_o   = 1'b0;

    unique case (phase_q)
      EP_IDLE: begin
        if (start_i) begin
          // zero prints one '0' unless the precision is exactly zero
          if (dig_i.ndig == '0 && !(has_prec && fmt_i.min_digits[5:0] == 6'd0)) begin
            ndig_d = i2a_pkg::CNT_W'(1);
          end else begin
            ndig_d = dig_i.ndig;
          end
          phase_d = EP_CALC1;
        end
      end
      EP_CALC1: begin
        pz_d   = pz_c;
        zf_d   = fmt_i.zero_fill && !has_prec;
        pre_d  = '{i2a_pkg::CH_ZERO, i2a_pkg::CH_ZERO, x_ch};
        plen_d = 2'd0;
        priority if (sign_on && hex_alt) begin
          pre_d  = '{sign_ch, i2a_pkg::CH_ZERO, x_ch};
          plen_d = 2'd3;
        end else if (sign_on && oct_alt) begin
          pre_d  = '{sign_ch, i2a_pkg::CH_ZERO, x_ch};
          plen_d = 2'd2;
        end else if (sign_on) begin
          pre_d  = '{sign_ch, i2a_pkg::CH_ZERO, x_ch};
          plen_d = 2'd1;
        end else if (hex_alt) begin
          pre_d  = '{i2a_pkg::CH_ZERO, x_ch, x_ch};
          plen_d = 2'd2;
        end else if (oct_alt) begin
          plen_d = 2'd1;
        end else begin
          plen_d = 2'd0;
        end
        phase_d = EP_CALC2;
      end
      EP_CALC2: begin
        // over-long run: drop precision zeros until it fits
        if (content_c > SW'(i2a_pkg::RUN_MAX)) begin
          pz_d      = LW'(SW'(i2a_pkg::RUN_MAX) - SW'(plen_q) - SW'(ndig_q));
          content_d = LW'(i2a_pkg::RUN_MAX);
        end else begin
          content_d = LW'(content_c);
        end
        phase_d = EP_CALC3;
      end
      EP_CALC3: begin
        b1_d    = lead_c;
        b2_d    = lead_c + LW'(plen_q);
        b4_d    = lead_c + LW'(plen_q) + zpad_c + pz_q;
        b5_d    = lead_c + LW'(plen_q) + zpad_c + pz_q + ndig_l;
        total_d = lead_c + content_q + zpad_c + trail_c;
        idx_d   = '0;
        phase_d = (lead_c + content_q + zpad_c + trail_c == '0) ? EP_IDLE : EP_RUN;
      end
      EP_RUN: begin
        if (load) begin
          valid_d = 1'b1;
          priority if (idx_q < b1_q) begin
            char_d = i2a_pkg::CH_SPACE;
          end else if (idx_q < b2_q) begin
            char_d = pre_q[pre_off[1:0]];
          end else if (idx_q < b4_q) begin
            char_d = i2a_pkg::CH_ZERO;
          end else if (idx_q < b5_q) begin
            char_d  = i2a_pkg::digit_char(dig_i.top_digit, fmt_i.upper_case);
            shift_o = 1'b1;
          end else begin
            char_d = i2a_pkg::CH_SPACE;
          end
          last_d = (idx_q == total_q - 1'b1);
          idx_d  = idx_q + 1'b1;
          if (idx_q == total_q - 1'b1) begin
            phase_d = EP_IDLE;
          end
        end
      end
      default: begin
        phase_d = EP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= EP_IDLE;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ndig_q    <= ndig_d;
    pz_q      <= pz_d;
    plen_q    <= plen_d;
    pre_q     <= pre_d;
    zf_q      <= zf_d;
    content_q <= content_d;
    b1_q      <= b1_d;
    b2_q      <= b2_d;
    b4_q      <= b4_d;
    b5_q      <= b5_d;
    total_q   <= total_d;
    idx_q     <= idx_d;
    char_q    <= char_d;
    last_q    <= last_d;
  end

  assign busy_o          = (phase_q != EP_IDLE);
  assign out_o.valid     = valid_q;
  assign out_o.out_char  = char_q;
  assign out_o.last_char = last_q;

endmodule

/* hdl/integer_to_ascii_formatter_top.sv */
`timescale 1ns / 1ps
// Path to the first character: decimal runs binary-to-BCD, then the leading-zero strip, then
// the layout start, the layout states and the output register; octal and hex skip the BCD.
// Throughput: one character word per cycle while the output is ready; one number at a time,
// so a new number is taken only after the last one's field has been sequenced.
// An empty field (zero, precision zero, width zero, no sign or prefix) emits no word at all.
// Reset: asynchronous, active low; clears the sequencers and the output valid.
module integer_to_ascii_formatter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2a_in_if.sink      in_i,
  i2a_out_if.source   out_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]          state_q, state_d;
  i2a_pkg::fmt_t       fmt_q;
  i2a_pkg::dig_stat_t  dig_stat;
  logic                accept;
  logic                emit_start;
  logic                emit_busy;
  logic                dig_shift;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign emit_start = (state_q == ST_CONV) && dig_stat.done;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_CONV;
      ST_CONV: if (dig_stat.done) state_d = ST_EMIT;
      ST_EMIT: if (!emit_busy) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fmt_q.negative    <= in_i.negative;
      fmt_q.opcode      <= in_i.opcode;
      fmt_q.upper_case  <= in_i.upper_case;
      fmt_q.field_width <= in_i.field_width;
      fmt_q.min_digits  <= in_i.min_digits;
      fmt_q.zero_fill   <= in_i.zero_fill;
      fmt_q.align_left  <= in_i.align_left;
      fmt_q.force_plus  <= in_i.force_plus;
      fmt_q.alternate   <= in_i.alternate;
      fmt_q.is_zero     <= (in_i.magnitude[i2a_pkg::VALUE_BITS-1:0] == '0);
    end
  end

  i2a_digits u_digits (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .magnitude_i (in_i.magnitude[i2a_pkg::VALUE_BITS-1:0]),
    .opcode_i    (in_i.opcode),
    .shift_i     (dig_shift),
    .stat_o      (dig_stat)
  );

  i2a_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (emit_start),
    .fmt_i   (fmt_q),
    .dig_i   (dig_stat),
    .shift_o (dig_shift),
    .busy_o  (emit_busy),
    .out_o   (out_o)
  );

  // digits are only consumed once the digit register has settled
  assert property (@(posedge clk_i) disable iff (!rst_ni) dig_shift |-> dig_stat.done)
    else $error("digit shift before conversion finished");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_i.valid && in_i.ready) |-> !emit_busy)
    else $error("new word taken while the field is still being emitted");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(emit_busy) |-> $past(dig_stat.done))
    else $error("layout started without a finished digit register");

endmodule
